>>> design/tile_background_line_renderer_core_assert.svh
// Assertion macros for the background line renderer checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef TILE_BACKGROUND_LINE_RENDERER_CORE_ASSERT_SVH
`define TILE_BACKGROUND_LINE_RENDERER_CORE_ASSERT_SVH

// Property sampled on clk, ignored while reset is asserted.
`define TBLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property sampled on clk that also covers the reset cycles.
`define TBLR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/tblr_pkg.sv
// Shared types, codes and constants of the background line renderer.
// No dependencies.
package tblr_pkg;

  localparam int LINE_WIDTH_DEF = 160;
  localparam int TILE_COUNT_DEF = 256;

  localparam int MAP_DEPTH = 2048;
  localparam int MAP_AW    = 11;

  localparam logic [15:0] DISPLAY_BASE = 16'd6192;

  localparam logic [14:0] GRAY_0 = 15'h7FFF;
  localparam logic [14:0] GRAY_1 = 15'h6318;
  localparam logic [14:0] GRAY_2 = 15'h318C;
  localparam logic [14:0] GRAY_3 = 15'h0000;

  typedef enum logic [1:0] {
    OP_MAP_WR  = 2'd0,
    OP_TILE_WR = 2'd1,
    OP_RENDER  = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RENDER = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic map_wr;
    logic tile_wr;
    logic start;
    logic issue;
    logic last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic adv;
    logic s1_busy;
  } stat_t;

  function automatic logic [14:0] gray_color(logic [1:0] shade);
    logic [14:0] c;
    unique case (shade)
      2'd0: c = GRAY_0;
      2'd1: c = GRAY_1;
      2'd2: c = GRAY_2;
      default: c = GRAY_3;
    endcase
    return c;
  endfunction

endpackage

>>> design/tile_background_line_renderer_core.sv
// Write items (map byte, tile pixel) and unused op codes are taken back to back
// while no render is under way. A render item issues (LINE_WIDTH+3)/4 groups, one
// per cycle while the output is not stalled; a group passes the map, lane and
// output registers in order, and the next item waits for the last group to leave stage 1.
// Synchronous active-low reset clears control and map_select; both stores are
// left as they are and hold nothing meaningful until written.
module tile_background_line_renderer_core import tblr_pkg::*; #(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int TILE_COUNT = TILE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: map half select
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [10:0] in_map_address,
  input  logic [7:0]  in_map_byte,
  input  logic [7:0]  in_tile_number,
  input  logic [2:0]  in_pixel_x,
  input  logic [2:0]  in_pixel_y,
  input  logic [1:0]  in_color_index,
  input  logic [7:0]  in_line,
  input  logic [7:0]  in_scroll_x,
  input  logic [7:0]  in_scroll_y,
  // result channel: one beat per group of four pixels
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_pixel_a,
  output logic [14:0] out_pixel_b,
  output logic [14:0] out_pixel_c,
  output logic [14:0] out_pixel_d,
  output logic [15:0] out_display_address,
  output logic        out_last
);

  localparam int NGROUPS = (LINE_WIDTH + 3) / 4;
  localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

  cmd_t          cmd;
  stat_t         st;
  logic [GW-1:0] issue_group;

  // The controller owns the input handshake and walks the group counter. Each
  // issued group reads two map bytes (a group of four pixels spans at most two
  // tiles), then one shade per tile lane (four consecutive columns never hit
  // the same lane twice), then maps shades through the gray palette. The whole
  // pipeline advances together whenever the output register is free, so a
  // stalled beat holds every stage behind it.
  tblr_ctrl #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .st          (st),
    .cmd         (cmd),
    .issue_group (issue_group)
  );

  tblr_datapath #(
    .LINE_WIDTH (LINE_WIDTH),
    .TILE_COUNT (TILE_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .issue_group         (issue_group),
    .st                  (st),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_map_address      (in_map_address),
    .in_map_byte         (in_map_byte),
    .in_tile_number      (in_tile_number),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .in_color_index      (in_color_index),
    .in_line             (in_line),
    .in_scroll_x         (in_scroll_x),
    .in_scroll_y         (in_scroll_y),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_pixel_a         (out_pixel_a),
    .out_pixel_b         (out_pixel_b),
    .out_pixel_c         (out_pixel_c),
    .out_pixel_d         (out_pixel_d),
    .out_display_address (out_display_address),
    .out_last            (out_last)
  );

endmodule

>>> design/tblr_ctrl.sv
// Controller of the background line renderer: input handshake and group sequencer.
// Depends on tblr_pkg.
module tblr_ctrl import tblr_pkg::*; #(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF,
  localparam int NGROUPS = (LINE_WIDTH + 3) / 4,
  localparam int GW = (NGROUPS > 1) ? $clog2(NGROUPS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_op,
  input  stat_t         st,
  output cmd_t          cmd,
  output logic [GW-1:0] issue_group
);

  localparam logic [GW-1:0] LAST_G = GW'(NGROUPS - 1);

  state_t        state_r, state_nxt;
  logic [GW-1:0] group_r, group_nxt;
  logic          accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      group_r <= '0;
    end else begin
      state_r <= state_nxt;
      group_r <= group_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    group_nxt = group_r;
    cmd       = '0;
    // take an item only with the sequencer idle and no tile read pending
    in_stall  = !((state_r == ST_IDLE) && !st.s1_busy);
    accept    = in_valid && !in_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_op))
            OP_MAP_WR:  cmd.map_wr = 1'b1;
            OP_TILE_WR: cmd.tile_wr = 1'b1;
            OP_RENDER: begin
              cmd.start = 1'b1;
              group_nxt = '0;
              state_nxt = ST_RENDER;
            end
            default: ;
          endcase
        end
      end
      ST_RENDER: begin
        if (st.adv) begin
          cmd.issue = 1'b1;
          cmd.last  = (group_r == LAST_G);
          if (group_r == LAST_G) begin
            state_nxt = ST_IDLE;
          end else begin
            group_nxt = group_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign issue_group = group_r;

endmodule

>>> design/tblr_datapath.sv
// Datapath of the background line renderer: map store, eight tile pixel lanes,
// three-stage group pipeline and output register. Depends on tblr_pkg.
module tblr_datapath import tblr_pkg::*; #(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int TILE_COUNT = TILE_COUNT_DEF,
  localparam int NGROUPS = (LINE_WIDTH + 3) / 4,
  localparam int GW = (NGROUPS > 1) ? $clog2(NGROUPS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  input  logic [GW-1:0] issue_group,
  output stat_t         st,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic [10:0]   in_map_address,
  input  logic [7:0]    in_map_byte,
  input  logic [7:0]    in_tile_number,
  input  logic [2:0]    in_pixel_x,
  input  logic [2:0]    in_pixel_y,
  input  logic [1:0]    in_color_index,
  input  logic [7:0]    in_line,
  input  logic [7:0]    in_scroll_x,
  input  logic [7:0]    in_scroll_y,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [14:0]   out_pixel_a,
  output logic [14:0]   out_pixel_b,
  output logic [14:0]   out_pixel_c,
  output logic [14:0]   out_pixel_d,
  output logic [15:0]   out_display_address,
  output logic          out_last
);

  localparam int TW         = $clog2(TILE_COUNT);
  localparam int LANE_DEPTH = TILE_COUNT * 8;
  localparam logic [9:0] TC10 = 10'(TILE_COUNT);
  localparam logic [8:0] LW9  = 9'(LINE_WIDTH);

  // tile number modulo tile count; an 8-bit number stays below twice the count
  function automatic logic [TW-1:0] tile_wrap(logic [7:0] t);
    logic [9:0] w;
    w = {2'b00, t};
    if (w >= TC10) begin
      w = w - TC10;
    end
    return w[TW-1:0];
  endfunction

  logic        map_select_r;
  logic [7:0]  ypos_r;
  logic [7:0]  sx_r;
  logic [15:0] base_r;
  logic        adv;

  // stage 0 -> 1: map bytes
  logic [7:0]  map_mem [MAP_DEPTH];
  logic [7:0]  m0_r, m1_r;
  logic        s1_valid_r;
  logic [2:0]  s1_xlow_r;
  logic [7:0]  s1_col0_r;
  logic [15:0] s1_addr_r;
  logic        s1_last_r;

  // stage 1 -> 2: lane shades
  logic [15:0] lane_q_r;
  logic        s2_valid_r;
  logic [2:0]  s2_xlow_r;
  logic [7:0]  s2_col0_r;
  logic [15:0] s2_addr_r;
  logic        s2_last_r;

  // output register
  logic        out_valid_r;
  logic [14:0] pix_r [4];
  logic [15:0] out_addr_r;
  logic        out_last_r;

  logic [7:0]        col0_s0;
  logic [7:0]        xpos0_s0;
  logic [4:0]        c0_s0, c1_s0;
  logic [MAP_AW-1:0] maddr0, maddr1;
  logic [TW-1:0]     tile0_mod, tile1_mod;
  logic [TW+2:0]     tile_wr_addr;
  logic [31:0]       lane_rot;

  assign adv        = !out_valid_r || !out_stall;
  assign st.adv     = adv;
  assign st.s1_busy = s1_valid_r;

  // configuration and line setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_select_r <= 1'b0;
    end else if (cfg_wr_en) begin
      map_select_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ypos_r <= in_line + in_scroll_y;
      sx_r   <= in_scroll_x;
      base_r <= DISPLAY_BASE + {in_line, 8'h00};
    end
  end

  // stage 0: two map reads cover the at most two tiles of a group
  always_comb begin
    col0_s0  = 8'({issue_group, 2'b00});
    xpos0_s0 = sx_r + col0_s0;
    c0_s0    = xpos0_s0[7:3];
    c1_s0    = c0_s0 + 5'd1;
    maddr0   = {map_select_r, ypos_r[7:3], c0_s0};
    maddr1   = {map_select_r, ypos_r[7:3], c1_s0};
  end

  always_ff @(posedge clk) begin
    if (cmd.map_wr) begin
      map_mem[in_map_address] <= in_map_byte;
    end
    if (cmd.issue) begin
      m0_r <= map_mem[maddr0];
      m1_r <= map_mem[maddr1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xlow_r <= xpos0_s0[2:0];
      s1_col0_r <= col0_s0;
      s1_addr_r <= base_r + {8'h00, col0_s0};
      s1_last_r <= cmd.last;
    end
  end

  // stage 1: each lane holds one pixel column of every tile row
  assign tile0_mod    = tile_wrap(m0_r);
  assign tile1_mod    = tile_wrap(m1_r);
  assign tile_wr_addr = {tile_wrap(in_tile_number), in_pixel_y};

  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [1:0]    mem [LANE_DEPTH];
    logic [TW+2:0] rd_addr;

    // lanes left of the first pixel's column belong to the second tile
    assign rd_addr = {(3'(l) < s1_xlow_r) ? tile1_mod : tile0_mod, ypos_r[2:0]};

    always_ff @(posedge clk) begin
      if (cmd.tile_wr && (in_pixel_x == 3'(l))) begin
        mem[tile_wr_addr] <= in_color_index;
      end
      if (adv) begin
        lane_q_r[2*l +: 2] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_xlow_r <= s1_xlow_r;
      s2_col0_r <= s1_col0_r;
      s2_addr_r <= s1_addr_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 2: rotate lanes into pixel order, map through the palette
  assign lane_rot = {lane_q_r, lane_q_r} >> {s2_xlow_r, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        if (({1'b0, s2_col0_r} + 9'(k)) < LW9) begin
          pix_r[k] <= gray_color(lane_rot[2*k +: 2]);
        end else begin
          pix_r[k] <= 15'd0;
        end
      end
      out_addr_r <= s2_addr_r;
      out_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= cmd.issue;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_a         = pix_r[0];
  assign out_pixel_b         = pix_r[1];
  assign out_pixel_c         = pix_r[2];
  assign out_pixel_d         = pix_r[3];
  assign out_display_address = out_addr_r;
  assign out_last            = out_last_r;

endmodule

>>> design/tblr_checker.sv
// Port-level checker of the background line renderer, bound to the top level.
// Depends on tblr_pkg and tile_background_line_renderer_core_assert.svh.
`include "tile_background_line_renderer_core_assert.svh"

module tblr_checker import tblr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] out_pixel_a,
  input logic [14:0] out_pixel_b,
  input logic [14:0] out_pixel_c,
  input logic [14:0] out_pixel_d,
  input logic [15:0] out_display_address,
  input logic        out_last
);

  // no beat may appear straight out of reset
  `TBLR_ASSERT_RST(a_no_beat_after_reset, !rst_n |=> !out_valid, "beat right after reset")

  // a stalled beat stays valid and holds pixel a, its address and its last flag
  `TBLR_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_pixel_a) && $stable(out_display_address) && $stable(out_last), "stalled beat changed")

  // pixel a of every beat is a palette gray
  `TBLR_ASSERT(a_gray_only, out_valid |-> (out_pixel_a == GRAY_0 || out_pixel_a == GRAY_1 || out_pixel_a == GRAY_2 || out_pixel_a == GRAY_3), "pixel outside palette")

  // groups of one line follow each other four columns apart
  `TBLR_ASSERT(a_group_step, (out_valid && !out_stall && !out_last) ##1 out_valid |-> out_display_address == $past(out_display_address) + 16'd4, "group address step wrong")

endmodule

bind tile_background_line_renderer_core tblr_checker u_chk (.*);

>>> verif/tb_tile_background_line_renderer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for tile_background_line_renderer_core: directed and random
// beats, with every pixel group compared against mirrors of both stores kept in the bench.
// Depends on tblr_pkg and tile_background_line_renderer_core.
module tb_tile_background_line_renderer_core;
  import tblr_pkg::*;

  localparam int LINE_W        = LINE_WIDTH_DEF;
  localparam int TILES         = TILE_COUNT_DEF;
  localparam int GROUPS        = (LINE_W + 3) / 4;
  localparam int MAP_HALF_SIZE = MAP_DEPTH / 2;
  localparam int SHADE_DEPTH   = TILES * 64;
  localparam logic [1:0] OP_NONE = 2'd3;  // unused op code, must be ignored
  localparam int IDLE_PCT      = 31;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 8;       // lets the last write beat retire
  localparam int TAIL_CYCLES   = 60;      // longer than one full line render

  // One input beat, fields in port order
  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] map_address;
    logic [7:0]  map_byte;
    logic [7:0]  tile_number;
    logic [2:0]  pixel_x;
    logic [2:0]  pixel_y;
    logic [1:0]  color_index;
    logic [7:0]  line;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
  } beat_t;

  // One result beat: four pixels and where they land
  typedef struct packed {
    logic [14:0] pixel_a, pixel_b, pixel_c, pixel_d;
    logic [15:0] display_address;
    logic        last;
  } group_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [10:0] in_map_address;
  logic [7:0]  in_map_byte;
  logic [7:0]  in_tile_number;
  logic [2:0]  in_pixel_x;
  logic [2:0]  in_pixel_y;
  logic [1:0]  in_color_index;
  logic [7:0]  in_line;
  logic [7:0]  in_scroll_x;
  logic [7:0]  in_scroll_y;
  logic        out_valid;
  logic        out_stall;
  logic [14:0] out_pixel_a;
  logic [14:0] out_pixel_b;
  logic [14:0] out_pixel_c;
  logic [14:0] out_pixel_d;
  logic [15:0] out_display_address;
  logic        out_last;

  tile_background_line_renderer_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_map_address      (in_map_address),
    .in_map_byte         (in_map_byte),
    .in_tile_number      (in_tile_number),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .in_color_index      (in_color_index),
    .in_line             (in_line),
    .in_scroll_x         (in_scroll_x),
    .in_scroll_y         (in_scroll_y),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pixel_a         (out_pixel_a),
    .out_pixel_b         (out_pixel_b),
    .out_pixel_c         (out_pixel_c),
    .out_pixel_d         (out_pixel_d),
    .out_display_address (out_display_address),
    .out_last            (out_last)
  );

  // Mirrors of the two stores, with a written flag per entry so that a render
  // never touches anything the block holds undefined.
  logic [7:0]  map_mirror   [MAP_DEPTH];
  logic [1:0]  shade_mirror [SHADE_DEPTH];
  bit          map_known    [MAP_DEPTH];
  bit          shade_known  [SHADE_DEPTH];
  logic        map_half;
  logic [14:0] gray_rgb [4];

  group_t pending_groups [$];  // predicted pixel groups, oldest first

  int  errors;
  int  beats_sent;
  int  renders_sent;
  int  unused_sent;
  int  groups_checked;
  int  half_writes;
  bit  calm;                   // set: neither side idles

  // -------------------------------------------------------------------------
  // Clock, watchdog and result-side stall
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Far beyond the slowest legal run, even with every fill write and stall
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // Drop the receiver into stall at random, except through the calm stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  task automatic flag(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, want,
                             input logic [15:0] where);
    if (got !== want)
      flag($sformatf("group at %0d, %s: expected %h, got %h", where, name, want, got));
  endtask

  // Compare every accepted result beat, field by field, with the oldest prediction
  always @(posedge clk) begin : check_group
    group_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_groups.size() == 0) begin
        flag($sformatf("result beat at %0d with no group expected", out_display_address));
      end else begin
        want = pending_groups.pop_front();
        groups_checked++;
        check_field("pixel_a", {1'b0, out_pixel_a}, {1'b0, want.pixel_a},
                    want.display_address);
        check_field("pixel_b", {1'b0, out_pixel_b}, {1'b0, want.pixel_b},
                    want.display_address);
        check_field("pixel_c", {1'b0, out_pixel_c}, {1'b0, want.pixel_c},
                    want.display_address);
        check_field("pixel_d", {1'b0, out_pixel_d}, {1'b0, want.pixel_d},
                    want.display_address);
        check_field("display_address", out_display_address, want.display_address,
                    want.display_address);
        check_field("last", {15'd0, out_last}, {15'd0, want.last}, want.display_address);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------
  function automatic int shade_slot(input logic [7:0] tile, input logic [2:0] px, py);
    return (int'(tile) % TILES) * 64 + int'(py) * 8 + int'(px);
  endfunction

  // Map entry read for background position (xpos, ypos) in the selected half
  function automatic int map_slot(input logic [7:0] ypos, xpos);
    return ((map_half ? MAP_HALF_SIZE : 0) + int'(ypos[7:3]) * 32 + int'(xpos[7:3]))
           % MAP_DEPTH;
  endfunction

  // Walk the line exactly as the display sees it and queue one group per four columns
  task automatic predict_line_groups(input beat_t b);
    logic [7:0]  ypos;
    logic [7:0]  xpos;
    logic [7:0]  tile;
    logic [14:0] rgb [4];
    int          col;
    group_t      grp;
    ypos = b.line + b.scroll_y;
    for (int g = 0; g < GROUPS; g++) begin
      for (int k = 0; k < 4; k++) begin
        col = g * 4 + k;
        rgb[k] = '0;          // columns past the line end read as zero
        if (col < LINE_W) begin
          xpos = b.scroll_x + 8'(col);
          tile = map_mirror[map_slot(ypos, xpos)];
          rgb[k] = gray_rgb[shade_mirror[shade_slot(tile, xpos[2:0], ypos[2:0])]];
        end
      end
      grp.pixel_a = rgb[0];
      grp.pixel_b = rgb[1];
      grp.pixel_c = rgb[2];
      grp.pixel_d = rgb[3];
      // wraps at 16 bits for lines 232 and above
      grp.display_address = DISPLAY_BASE + 16'(int'(b.line) * 256 + g * 4);
      grp.last = (g == GROUPS - 1);
      pending_groups.push_back(grp);
    end
    renders_sent++;
  endtask

  // Advance the mirrors by one accepted beat
  task automatic apply_beat(input beat_t b);
    int slot;
    case (b.op)
      OP_MAP_WR: begin
        map_mirror[b.map_address] = b.map_byte;
        map_known[b.map_address]  = 1'b1;
      end
      OP_TILE_WR: begin
        slot = shade_slot(b.tile_number, b.pixel_x, b.pixel_y);
        shade_mirror[slot] = b.color_index;
        shade_known[slot]  = 1'b1;
      end
      OP_RENDER: predict_line_groups(b);
      default: unused_sent++;
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Driving
  // -------------------------------------------------------------------------
  function automatic beat_t random_beat();
    logic [63:0] r;
    beat_t       b;
    r = {$urandom, $urandom};
    b = r[$bits(beat_t)-1:0];
    return b;
  endfunction

  // Hold the beat until it is taken, after an optional random idle gap
  task automatic send_beat(input beat_t b);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op          = b.op;
    in_map_address = b.map_address;
    in_map_byte    = b.map_byte;
    in_tile_number = b.tile_number;
    in_pixel_x     = b.pixel_x;
    in_pixel_y     = b.pixel_y;
    in_color_index = b.color_index;
    in_line        = b.line;
    in_scroll_x    = b.scroll_x;
    in_scroll_y    = b.scroll_y;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    apply_beat(b);
  endtask

  // Drop valid and wait for every predicted group to come out
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
  endtask

  // Only touch the register with the block idle: drained and past any write beat
  task automatic set_map_half(input logic v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    map_half    = v;
    half_writes++;
  endtask

  // Write whatever map bytes and tile pixels the coming line will read but that
  // were never written; the fills carry random content.
  task automatic prepare_line(input logic [7:0] line_no, sx, sy);
    logic [7:0] ypos;
    logic [7:0] xpos;
    int         mslot;
    beat_t      b;
    ypos = line_no + sy;
    for (int col = 0; col < LINE_W; col++) begin
      xpos  = sx + 8'(col);
      mslot = map_slot(ypos, xpos);
      if (!map_known[mslot]) begin
        b = random_beat();
        b.op = OP_MAP_WR;
        b.map_address = 11'(mslot);
        send_beat(b);
      end
      if (!shade_known[shade_slot(map_mirror[mslot], xpos[2:0], ypos[2:0])]) begin
        b = random_beat();
        b.op          = OP_TILE_WR;
        b.tile_number = map_mirror[mslot];
        b.pixel_x     = xpos[2:0];
        b.pixel_y     = ypos[2:0];
        send_beat(b);
      end
    end
  endtask

  task automatic render_line(input logic [7:0] line_no, sx, sy);
    beat_t b;
    prepare_line(line_no, sx, sy);
    b = random_beat();
    b.op       = OP_RENDER;
    b.line     = line_no;
    b.scroll_x = sx;
    b.scroll_y = sy;
    send_beat(b);
  endtask

  task automatic write_map(input logic [10:0] addr, input logic [7:0] tile);
    beat_t b;
    b = random_beat();
    b.op          = OP_MAP_WR;
    b.map_address = addr;
    b.map_byte    = tile;
    send_beat(b);
  endtask

  task automatic write_pixel(input logic [7:0] tile, input logic [2:0] px, py,
                             input logic [1:0] shade);
    beat_t b;
    b = random_beat();
    b.op          = OP_TILE_WR;
    b.tile_number = tile;
    b.pixel_x     = px;
    b.pixel_y     = py;
    b.color_index = shade;
    send_beat(b);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Corner addresses and bytes of the map, corner pixels and every shade
  task automatic test_store_extremes();
    write_map(11'd0, 8'd0);
    write_map(11'd2047, 8'd255);
    write_map(11'd1024, 8'h5A);
    write_pixel(8'd0, 3'd0, 3'd0, 2'd0);
    write_pixel(8'd255, 3'd7, 3'd7, 2'd3);
    write_pixel(8'd128, 3'd3, 3'd4, 2'd1);
    write_pixel(8'd1, 3'd4, 3'd3, 2'd2);
  endtask

  // First and last visible line, full scroll in both axes, and a line past the
  // screen whose display address wraps at 16 bits
  task automatic test_line_extremes();
    render_line(8'd0, 8'd0, 8'd0);
    render_line(8'd143, 8'd255, 8'd255);
    render_line(8'd255, 8'hAA, 8'h55);
  endtask

  // Switch to the upper map half; line 255 with scroll 248 reads map entry 2047
  // and pixel (7,7) of tile 255
  task automatic test_upper_map_half();
    set_map_half(1'b1);
    render_line(8'd255, 8'd248, 8'd0);
    render_line(8'd72, 8'd7, 8'd200);
    set_map_half(1'b0);
  endtask

  // Unused op beats aimed at the row about to be rendered must leave no trace
  task automatic test_unused_op();
    beat_t b;
    for (int i = 0; i < 2; i++) begin
      b = random_beat();
      b.op          = OP_NONE;
      b.map_address = 11'($urandom_range(0, 31));
      send_beat(b);
    end
    render_line(8'd0, 8'd0, 8'd0);
  endtask

  // Hold the sender until the line is out, then resume with a map write, a pixel write and another line
  task automatic test_drain_pause();
    render_line(8'($urandom_range(0, 143)), 8'($urandom), 8'($urandom));
    wait_drain();
    write_map(11'($urandom_range(0, 2047)), 8'($urandom));
    write_pixel(8'($urandom), 3'($urandom), 3'($urandom), 2'($urandom));
    render_line(8'($urandom_range(0, 143)), 8'($urandom), 8'($urandom));
  endtask

  // Random mix of writes, renders and unused ops under one map half. Ignored
  // beats do not count towards the total.
  task automatic test_random_mix(input int count, input logic half, input bit with_calm);
    beat_t b;
    int    pick;
    int    taken;
    taken = 0;
    set_map_half(half);
    while (taken < count) begin
      calm = with_calm && (taken >= count / 4) && (taken < count / 4 + 40);
      if (taken % 40 == 39) wait_drain();
      pick = $urandom_range(0, 99);
      b = random_beat();
      if (pick < 18) begin
        b.line = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 143))
                                              : 8'($urandom_range(144, 255));
        render_line(b.line, b.scroll_x, b.scroll_y);
        taken++;
      end else if (pick < 48) begin
        b.op = OP_MAP_WR;
        send_beat(b);
        taken++;
      end else if (pick < 94) begin
        b.op = OP_TILE_WR;
        send_beat(b);
        taken++;
      end else begin
        b.op = OP_NONE;
        send_beat(b);
      end
    end
    calm = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    gray_rgb[0] = GRAY_0;
    gray_rgb[1] = GRAY_1;
    gray_rgb[2] = GRAY_2;
    gray_rgb[3] = GRAY_3;
    map_half    = 1'b0;
    calm        = 1'b0;
    errors      = 0;

    // Every input known from time zero while reset is held
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_MAP_WR;
    in_map_address = '0;
    in_map_byte    = '0;
    in_tile_number = '0;
    in_pixel_x     = '0;
    in_pixel_y     = '0;
    in_color_index = '0;
    in_line        = '0;
    in_scroll_x    = '0;
    in_scroll_y    = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    set_map_half(1'b0);
    test_store_extremes();
    test_line_extremes();
    test_upper_map_half();
    test_unused_op();
    test_drain_pause();
    test_random_mix(90, 1'b1, 1'b0);
    test_random_mix(90, 1'b0, 1'b1);
    test_random_mix(80, 1'b1, 1'b0);

    // Let the last line drain, then give a stray beat time to show up
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats: %0d line renders, %0d unused-op beats, %0d map-half writes.",
             beats_sent, renders_sent, unused_sent, half_writes);
    $display("%0d pixel groups checked, %0d problems found.", groups_checked, errors);
    if (errors == 0 && pending_groups.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> tile_background_line_renderer_core.f
+incdir+design
design/tblr_pkg.sv
design/tblr_ctrl.sv
design/tblr_datapath.sv
design/tile_background_line_renderer_core.sv
design/tblr_checker.sv
verif/tb_tile_background_line_renderer_core.sv
